/* src/lir_pkg.sv */
// Package for the linear interpolation resampler: widths, register indexes,
// beat structs and the front-to-back job format. No dependencies.
package lir_pkg;

	localparam int MaxPointsDefault = 64;
	localparam int FracBits = 20;
	localparam int CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_START_TIME   = 3'd0,
		REG_GRID_STEP    = 3'd1,
		REG_OUTPUT_COUNT = 3'd2,
		REG_NORMALIZE_ON = 3'd3,
		REG_NORM_MIN     = 3'd4,
		REG_NORM_MAX     = 3'd5
	} reg_idx_t;

	// one accepted sample, with the bracket left behind by the previous one
	typedef struct packed {
		logic [31:0]        t1;
		logic signed [15:0] v1;
		logic               fin;
		logic [31:0]        prev_time;
		logic signed [15:0] prev_value;
		logic               have_prev;
	} job_t;

	typedef struct packed {
		logic [31:0] start_time;
		logic [23:0] grid_step;
		logic [6:0]  output_count;
		logic        normalize_on;
		logic signed [15:0] norm_min;
		logic signed [15:0] norm_max;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_GRID, ST_CHECK, ST_MUL, ST_DIV1, ST_ADD, ST_NMUL, ST_DIV2,
		ST_SAT, ST_EMIT, ST_PADCONV, ST_PADDIV, ST_PAD
	} back_state_t;

endpackage

/* src/lir_divider.sv */
// Serial restoring divider for unsigned division, one quotient bit a cycle.
// Depends on lir_pkg (style only).
module lir_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [32:0] den,
	output logic        done,
	output logic [63:0] quo
);
	import lir_pkg::*;

	logic [63:0] q_q;
	logic [33:0] rem_q;
	logic [32:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [33:0] trial;

	assign trial = {rem_q[32:0], q_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial;
				q_q   <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[32:0], q_q[63]};
				q_q   <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign quo = q_q;
endmodule

/* src/lir_front.sv */
// Front end: accepts sample beats, keeps the left bracket, queues jobs.
// Depends on lir_pkg.
module lir_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [31:0]   in_time,
	input  logic [15:0]   in_value,
	input  logic          in_fin,
	output lir_pkg::job_t job,
	output logic          job_valid,
	input  logic          job_take
);
	import lir_pkg::*;

	job_t       slot_q [2];
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	logic [31:0] prev_time_q;
	logic [15:0] prev_value_q;
	logic        have_prev_q;
	logic        push;
	job_t        nj;

	assign in_ready  = cnt_q != 2'd2;
	assign push      = in_valid && in_ready;
	assign job_valid = cnt_q != 2'd0;
	assign job       = slot_q[rd_q];

	always_comb begin
		nj.t1 = in_time;
		nj.v1 = in_value;
		nj.fin = in_fin;
		nj.prev_time = prev_time_q;
		nj.prev_value = prev_value_q;
		nj.have_prev = have_prev_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			prev_time_q <= '0;
			prev_value_q <= '0;
			have_prev_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
				if (in_fin) begin
					have_prev_q <= 1'b0;
				end else begin
					prev_time_q <= in_time;
					prev_value_q <= in_value;
					have_prev_q <= 1'b1;
				end
			end
			if (job_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, job_take};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= nj;
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) cnt_q == 2'd2 |-> !push;
	endproperty
	a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> job_valid) else $error("queue underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("bad count");
endmodule

/* src/lir_back.sv */
// Back end: walks grid points for one job, interpolates, normalizes, pads.
// Depends on lir_pkg and lir_divider.
module lir_back #(
	parameter int MAX_POINTS = lir_pkg::MaxPointsDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lir_pkg::cfg_t cfg,
	input  lir_pkg::job_t job,
	input  logic          job_valid,
	output logic          job_take,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   out_time,
	output logic [23:0]   out_value,
	output logic          out_padded,
	output logic          out_run_last,
	output logic          out_window_done,
	output logic          idle
);
	import lir_pkg::*;

	localparam int CapI = (MAX_POINTS < 64) ? MAX_POINTS : 64;
	localparam logic [6:0] Cap = 7'(CapI);

	back_state_t st_q, st_d;
	logic [6:0]  pts_q;
	logic [23:0] last_q;
	logic [32:0] g_q;
	logic signed [63:0] acc_q;
	logic        neg_q;
	logic signed [23:0] val_q;
	logic [23:0] pad_q;
	logic        ovalid_q;
	logic [6:0]  n_eff;
	logic [23:0] step_eff;
	logic signed [16:0] diff;
	logic [15:0] dmag;
	logic [31:0] gdelta;
	logic [47:0] prod;
	logic [32:0] dt;
	logic signed [16:0] nden;
	logic        div_start, div_done;
	logic [63:0] div_num, div_quo;
	logic [32:0] div_den;
	logic        any_due;
	logic        g_due;
	logic        fire;

	assign step_eff = (cfg.grid_step == '0) ? 24'd1 : cfg.grid_step;
	always_comb begin
		n_eff = cfg.output_count;
		if (n_eff == '0) n_eff = 7'd1;
		if (n_eff > Cap) n_eff = Cap;
	end
	assign diff = 17'(job.v1) - 17'(job.prev_value);
	assign dmag = (diff < 0) ? 16'(-diff) : 16'(diff);
	// only used when the point lies inside the bracket, so it fits 32 bits
	assign gdelta = 32'(g_q - {1'b0, job.prev_time});
	assign prod = dmag * gdelta;
	assign dt   = {1'b0, job.t1} - {1'b0, job.prev_time};
	assign nden = 17'(cfg.norm_max) - 17'(cfg.norm_min);
	assign g_due = g_q <= {1'b0, job.t1};
	assign idle = (st_q == ST_IDLE) && !ovalid_q;

	lir_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(div_quo)
	);

	// magnitude with half-divisor added: rounds to nearest, ties away from zero
	always_comb begin
		div_start = 1'b0;
		div_num = '0;
		div_den = dt;
		if (st_q == ST_MUL) begin
			div_start = 1'b1;
			div_num = 64'(acc_q) + 64'(dt >> 1);
		end else if (st_q == ST_NMUL || st_q == ST_PADCONV) begin
			div_start = 1'b1;
			div_den = 33'(unsigned'(nden));
			div_num = (neg_q ? 64'(-acc_q) : 64'(acc_q)) + 64'(unsigned'(nden) >> 1);
		end
	end

	logic signed [63:0] q_signed;
	assign q_signed = neg_q ? -signed'(div_quo) : signed'(div_quo);

	function automatic logic [23:0] sat24(input logic signed [63:0] v);
		if (v > 64'sd8388607) return 24'h7FFFFF;
		if (v < -64'sd8388608) return 24'h800000;
		return v[23:0];
	endfunction

	always_comb begin
		st_d = st_q;
		job_take = 1'b0;
		any_due = 1'b0;
		unique case (st_q)
			ST_IDLE: if (job_valid) st_d = ST_GRID;
			ST_GRID: st_d = ST_CHECK;
			ST_CHECK: begin
				any_due = (pts_q < n_eff) && g_due;
				if (any_due) st_d = (job.have_prev && g_q > {1'b0, job.prev_time})
					? ST_MUL : ST_ADD;
				else if (job.fin) begin
					// window already full: nothing to pad, just close it
					if (pts_q >= n_eff) begin
						job_take = 1'b1;
						st_d = ST_IDLE;
					end else if (pts_q == '0 && cfg.normalize_on && nden > 0)
						st_d = ST_PADCONV;
					else
						st_d = ST_PAD;
				end else begin
					job_take = 1'b1;
					st_d = ST_IDLE;
				end
			end
			ST_MUL: st_d = ST_DIV1;
			ST_DIV1: if (div_done) st_d = ST_ADD;
			ST_ADD: st_d = cfg.normalize_on ? ((nden > 0) ? ST_NMUL : ST_SAT) : ST_SAT;
			ST_NMUL: st_d = ST_DIV2;
			ST_DIV2: if (div_done) st_d = ST_SAT;
			ST_SAT: st_d = ST_EMIT;
			ST_EMIT: if (!ovalid_q || out_ready) st_d = ST_GRID;
			ST_PADCONV: st_d = ST_PADDIV;
			ST_PADDIV: if (div_done) st_d = ST_PAD;
			ST_PAD: begin
				if ((!ovalid_q || out_ready) && (pts_q + 7'd1 >= n_eff || pts_q >= n_eff)) begin
					job_take = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	logic more_due;
	// the point after this one: is it due now (then this is not the run's last)
	assign more_due = (pts_q + 7'd1 < n_eff) &&
		(g_q + 33'(step_eff) <= {1'b0, job.t1});

	assign fire = (!ovalid_q || out_ready) &&
		(st_q == ST_EMIT || (st_q == ST_PAD && pts_q < n_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q <= '0;
			last_q <= '0;
			ovalid_q <= 1'b0;
			out_time <= '0;
			out_value <= '0;
			out_padded <= 1'b0;
			out_run_last <= 1'b0;
			out_window_done <= 1'b0;
		end else begin
			if (fire) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			unique case (st_q)
				ST_CHECK: if (!any_due && job.fin && pts_q >= n_eff) begin
					pts_q <= '0;
					last_q <= '0;
				end
				ST_EMIT: if (fire) begin
					out_time <= g_q[31:0];
					out_value <= val_q;
					out_padded <= 1'b0;
					out_run_last <= job.fin ? (pts_q + 7'd1 >= n_eff) : !more_due;
					out_window_done <= pts_q + 7'd1 >= n_eff;
					last_q <= val_q;
					pts_q <= pts_q + 7'd1;
				end
				ST_PAD: if (fire) begin
					out_time <= g_q[31:0];
					out_value <= pad_q;
					out_padded <= 1'b1;
					out_run_last <= pts_q + 7'd1 >= n_eff;
					out_window_done <= pts_q + 7'd1 >= n_eff;
					if (pts_q + 7'd1 >= n_eff) begin
						pts_q <= '0;
						last_q <= '0;
					end else begin
						pts_q <= pts_q + 7'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_GRID: begin
				g_q <= {1'b0, cfg.start_time} + 33'(pts_q + 7'd1) * 33'(step_eff);
				pad_q <= (pts_q != '0) ? last_q
					: (cfg.normalize_on ? 24'd0 : 24'(job.v1));
			end
			ST_CHECK: begin
				// interpolated or plain raw value lands in val_q before ADD
				val_q <= 24'(job.v1);
				if (!any_due && job.fin && pts_q == '0 && cfg.normalize_on) begin
					acc_q <= (64'(job.v1) - 64'(cfg.norm_min)) <<< FracBits;
					neg_q <= (17'(job.v1) - 17'(cfg.norm_min)) < 0;
				end else begin
					acc_q <= 64'(prod);
					neg_q <= diff < 0;
				end
			end
			ST_MUL: ;
			ST_DIV1: if (div_done) val_q <= 24'(64'(job.prev_value) + q_signed);
			ST_ADD: begin
				acc_q <= (st_d == ST_NMUL)
					? ((64'(val_q) - 64'(cfg.norm_min)) <<< FracBits) : 64'(val_q);
				neg_q <= 64'(val_q) - 64'(cfg.norm_min) < 0;
			end
			ST_NMUL: ;
			ST_DIV2: ;
			ST_SAT: val_q <= (cfg.normalize_on && !(nden > 0)) ? 24'd0
				: (cfg.normalize_on ? sat24(q_signed) : sat24(64'(val_q)));
			ST_PADCONV: ;
			ST_PADDIV: if (div_done) pad_q <= sat24(q_signed);
			ST_PAD: if (!ovalid_q || out_ready) g_q <= g_q + 33'(step_eff);
			default: ;
		endcase
	end

	assign out_valid = ovalid_q;

	a_pts_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pts_q <= Cap) else $error("point count overrun");
	a_take_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> job_valid) else $error("take without job");
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == ST_DIV1 || st_q == ST_DIV2 || st_q == ST_PADDIV))
		else $error("unexpected divide result");
endmodule

/* src/linear_interp_resampler_top.sv */
// Linear interpolation resampler. Samples (time, value, final flag) enter on the
// s_axis channel; grid points leave on m_axis. Configuration writes use cfg_*.
// A front stage accepts samples and tracks the left bracket; a two-entry queue
// feeds the back stage, which computes each grid point in turn.
// Per grid point: interpolation runs a 64-step serial divider, and
// normalization as well adds a second divide; a point with no left bracket
// skips the first divide. Padding beats follow, after a conversion through
// the divider when a normalized window pads with nothing emitted.
// A sample that causes no point passes through the idle, grid and check
// states of the back stage.
// Reset clears the bracket, the point counter and all configuration to defaults.
// When m_axis_tready is low the back stage holds; the queue then fills and
// s_axis_tready drops. The user writes configuration only while the block
// is idle; the block itself does not enforce it. cfg_ready is always high.
module linear_interp_resampler_top #(
	parameter int MAX_POINTS = lir_pkg::MaxPointsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // sample_time[31:0], sample_value[47:32]
	input  logic        s_axis_tlast,  // final_sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // out_time[31:0], out_value[55:32]
	output logic [1:0]  m_axis_tuser,  // padded[0], window_done[1]
	output logic        m_axis_tlast,  // run_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import lir_pkg::*;

	cfg_t  cfg_q;
	job_t  job;
	logic  job_valid, job_take, idle;
	logic [31:0] o_time;
	logic [23:0] o_value;
	logic  o_pad, o_last, o_done;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_time <= '0;
			cfg_q.grid_step <= 24'd1000;
			cfg_q.output_count <= 7'd32;
			cfg_q.normalize_on <= 1'b0;
			cfg_q.norm_min <= '0;
			cfg_q.norm_max <= 16'sd32767;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_START_TIME:   cfg_q.start_time <= cfg_data;
				REG_GRID_STEP:    cfg_q.grid_step <= cfg_data[23:0];
				REG_OUTPUT_COUNT: cfg_q.output_count <= cfg_data[6:0];
				REG_NORMALIZE_ON: cfg_q.normalize_on <= cfg_data[0];
				REG_NORM_MIN:     cfg_q.norm_min <= cfg_data[15:0];
				REG_NORM_MAX:     cfg_q.norm_max <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	lir_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_time(s_axis_tdata[31:0]), .in_value(s_axis_tdata[47:32]),
		.in_fin(s_axis_tlast),
		.job(job), .job_valid(job_valid), .job_take(job_take)
	);

	lir_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.job(job), .job_valid(job_valid), .job_take(job_take),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_time(o_time), .out_value(o_value), .out_padded(o_pad),
		.out_run_last(o_last), .out_window_done(o_done), .idle(idle)
	);

	assign m_axis_tdata = {o_value, o_time};
	assign m_axis_tuser = {o_done, o_pad};
	assign m_axis_tlast = o_last;

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> idle || !job_valid) else $error("config write while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("beat dropped");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] && m_axis_tuser[0] |-> m_axis_tlast)
		else $error("padded window end without run end");
endmodule
